// File: rtl/randomized_weighted_majority_defines.svh
// Assertion macros shared by the RTL of the weighted majority learner.
`ifndef RANDOMIZED_WEIGHTED_MAJORITY_DEFINES_SVH
`define RANDOMIZED_WEIGHTED_MAJORITY_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define RWM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define RWM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rwm_pkg.sv
package rwm_pkg;

  // Default number of experts the weight store is sized for.
  localparam int unsigned MAX_EXPERTS_DEFAULT = 32;

  // Q1.31 weight of one.
  localparam logic [31:0] WEIGHT_ONE = 32'h8000_0000;

  // Output scrambler multiplier of the xorshift64* generator.
  localparam logic [63:0] XS_MULT = 64'd2685821657736338717;

  localparam logic [63:0] SEED_RESET   = 64'd1234567891234567;
  localparam logic [15:0] FACTOR_RESET = 16'd58982;
  localparam logic [5:0]  ACTIVE_RESET = 6'd32;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRONG_FACTOR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_EXPERTS = 2'd2;

  // Operand pair for the shared multiplier.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;

  // One xorshift64 state advance.
  function automatic logic [63:0] xorshift_step(input logic [63:0] x);
    logic [63:0] s1;
    logic [63:0] s2;
    logic [63:0] s3;
    s1 = x ^ (x >> 12);
    s2 = s1 ^ (s1 << 25);
    s3 = s2 ^ (s2 >> 27);
    return s3;
  endfunction

endpackage

// File: rtl/rwm_weight_ram.sv
module rwm_weight_ram import rwm_pkg::*; #(
  parameter int unsigned Depth = MAX_EXPERTS_DEFAULT,
  parameter int unsigned AddrW = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [31:0]      wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [31:0]      rdata_o
);

  logic [31:0] mem [Depth];
  logic [Depth-1:0] vld_q;
  logic [31:0] rd_q;
  logic rd_vld_q;

  // An entry never written since reset reads as a weight of one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[raddr_i];
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[raddr_i];
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : WEIGHT_ONE;

endmodule

// File: rtl/rwm_mul_unit.sv
module rwm_mul_unit import rwm_pkg::*; (
  input  logic        clk_i,
  input  mul_req_t    req_i,
  output logic [63:0] prod_o
);

  logic [63:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(req_i.a) * 64'(req_i.b);
  end

  assign prod_o = prod_q;

endmodule

// File: rtl/randomized_weighted_majority.sv
// Randomized weighted majority learner. Each expert holds a Q1.31 weight. An
// advice word (mode 0) stores the experts' vote bits and returns one guess word:
// 1 with probability (weight voting 1) / (total weight), drawn from an xorshift64*
// generator, or a fair coin when all weights are zero. An outcome word (mode 1)
// returns nothing; it scales the weight of every active expert whose stored
// vote was wrong by wrong_factor (Q0.16), doubles all active weights when all
// fell below one half, and restores them to one when all reached zero. An
// advice word also waits while the previous guess still occupies the output
// register, and an outcome word is followed by a doubling pass or a restore
// pass when one is due. Each pass sweeps the single read port of the weight
// memory once, and one 32x32 multiplier is shared by the weight scaling and
// by the five partial products of the random draw and comparison.
// The input side stalls while a word is being worked on; a finished guess sits
// in an output register, so the next word may be accepted while it waits.
// Configuration writes are taken only while the block is idle.
`include "randomized_weighted_majority_defines.svh"

module randomized_weighted_majority import rwm_pkg::*; #(
  parameter int unsigned MaxExperts = MAX_EXPERTS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input channel.
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 mode_i,
  input  logic [31:0]          expert_votes_i,
  input  logic                 outcome_i,
  // Output channel.
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 guess_o,
  // Configuration write channel.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]          cfg_data_i
);

  localparam int unsigned IdxW = (MaxExperts > 1) ? $clog2(MaxExperts) : 1;
  localparam int unsigned CntW = $clog2(MaxExperts + 1);
  // Exact sum of all active weights.
  localparam int unsigned SumW = 32 + IdxW;
  localparam int unsigned PhiW = SumW + 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_RNG,
    S_M0,
    S_M1,
    S_M2,
    S_M3,
    S_M4,
    S_M5,
    S_M6,
    S_CMP,
    S_UPD,
    S_DBL,
    S_FILL
  } state_e;

  state_e state_q;

  // Configuration and architectural state.
  logic [15:0] factor_q;
  logic [5:0]  active_q;
  logic [63:0] gen_q;
  logic [31:0] held_votes_q;

  // Sweep counter and the two read pipeline stages.
  logic [CntW-1:0] rc_q;
  logic            s1_v_q;
  logic            s2_v_q;
  logic [IdxW-1:0] s1_idx_q;
  logic [IdxW-1:0] s2_idx_q;
  logic [31:0]     s2_w_q;
  logic            s2_wrong_q;

  // Datapath registers.
  logic [SumW-1:0] total_q;
  logic [SumW-1:0] sum1_q;
  logic [31:0]     t_q;
  logic [PhiW-1:0] phi_q;
  logic            outcome_q;
  logic            all_small_q;
  logic            all_zero_q;
  logic            out_valid_q;
  logic            guess_q;

  logic [CntW-1:0] n_eff;
  logic [6:0]      act_ext;
  logic [6:0]      s1_idx_ext;
  logic            rd_issue;
  logic            vote_s1;
  logic            wrong_s1;
  logic [31:0]     rd_data;
  logic [63:0]     prod;
  mul_req_t        mul_req;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [31:0]     wr_data;
  logic            guess_d;

  // Active count of zero acts as one, and counts above the store size clip.
  assign act_ext = 7'(active_q);
  always_comb begin
    if (act_ext == 7'd0) begin
      n_eff = CntW'(1);
    end else if (act_ext > 7'(MaxExperts)) begin
      n_eff = CntW'(MaxExperts);
    end else begin
      n_eff = CntW'(act_ext);
    end
  end

  assign rd_issue = (state_q == S_SUM || state_q == S_UPD || state_q == S_DBL) &&
                    (rc_q < n_eff);

  // Experts numbered 32 and up have no vote bit and always vote 0.
  assign s1_idx_ext = 7'(s1_idx_q);
  assign vote_s1    = (s1_idx_ext < 7'd32) ? held_votes_q[s1_idx_ext[4:0]] : 1'b0;
  assign wrong_s1   = vote_s1 != outcome_q;

  // Operand selection for the shared multiplier. The random word is
  // x * XS_MULT mod 2^64, of which only the upper half is needed, so three
  // 32-bit partial products suffice.
  always_comb begin
    mul_req = '0;
    case (state_q)
      S_UPD: begin
        mul_req.a = rd_data;
        mul_req.b = {16'd0, factor_q};
      end
      S_M0: begin
        mul_req.a = gen_q[31:0];
        mul_req.b = XS_MULT[31:0];
      end
      S_M1: begin
        mul_req.a = gen_q[31:0];
        mul_req.b = XS_MULT[63:32];
      end
      S_M2: begin
        mul_req.a = gen_q[63:32];
        mul_req.b = XS_MULT[31:0];
      end
      S_M4: begin
        mul_req.a = t_q;
        mul_req.b = total_q[31:0];
      end
      S_M5: begin
        mul_req.a = t_q;
        mul_req.b = 32'(total_q[SumW-1:32]);
      end
      default: begin
        mul_req = '0;
      end
    endcase
  end

  // Weight write port: scaled weights leave the second stage, doubled
  // weights the first, and the restore pass writes one per cycle.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = s2_idx_q;
    wr_data = s2_wrong_q ? prod[47:16] : s2_w_q;
    case (state_q)
      S_UPD: begin
        wr_en = s2_v_q;
      end
      S_DBL: begin
        wr_en   = s1_v_q;
        wr_addr = s1_idx_q;
        wr_data = {rd_data[30:0], 1'b0};
      end
      S_FILL: begin
        wr_en   = rc_q < n_eff;
        wr_addr = rc_q[IdxW-1:0];
        wr_data = WEIGHT_ONE;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // With no weight at all the guess is the inverted top bit of the draw.
  assign guess_d = (total_q == '0) ? ~t_q[31] : (phi_q < {1'b0, sum1_q});

  rwm_weight_ram #(
    .Depth(MaxExperts),
    .AddrW(IdxW)
  ) u_weight_ram (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .raddr_i(rc_q[IdxW-1:0]),
    .rdata_o(rd_data)
  );

  rwm_mul_unit u_mul_unit (
    .clk_i (clk_i),
    .req_i (mul_req),
    .prod_o(prod)
  );

  // Sequencer, configuration registers and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      factor_q     <= FACTOR_RESET;
      active_q     <= ACTIVE_RESET;
      gen_q        <= SEED_RESET;
      held_votes_q <= '0;
      rc_q         <= '0;
      s1_v_q       <= 1'b0;
      s2_v_q       <= 1'b0;
      all_small_q  <= 1'b1;
      all_zero_q   <= 1'b1;
      out_valid_q  <= 1'b0;
      guess_q      <= 1'b0;
    end else begin
      s1_v_q <= rd_issue;
      s2_v_q <= s1_v_q && (state_q == S_UPD);
      if (rd_issue) begin
        rc_q <= rc_q + CntW'(1);
      end
      // The compare step handles the output register on its own.
      if (out_valid_q && !out_stall_i && state_q != S_CMP) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cfg_valid_i) begin
            case (cfg_index_i)
              CFG_WRONG_FACTOR:   factor_q <= cfg_data_i[15:0];
              CFG_RANDOM_SEED:    gen_q    <= cfg_data_i;
              CFG_ACTIVE_EXPERTS: active_q <= cfg_data_i[5:0];
              default: begin
              end
            endcase
          end
          if (in_valid_i) begin
            rc_q <= '0;
            if (!mode_i) begin
              held_votes_q <= expert_votes_i;
              state_q      <= S_SUM;
            end else begin
              all_small_q <= 1'b1;
              all_zero_q  <= 1'b1;
              state_q     <= S_UPD;
            end
          end
        end
        S_SUM: begin
          if (!rd_issue && !s1_v_q) begin
            state_q <= S_RNG;
          end
        end
        S_RNG: begin
          gen_q   <= xorshift_step(gen_q);
          state_q <= S_M0;
        end
        S_M0: state_q <= S_M1;
        S_M1: state_q <= S_M2;
        S_M2: state_q <= S_M3;
        S_M3: state_q <= S_M4;
        S_M4: state_q <= S_M5;
        S_M5: state_q <= S_M6;
        S_M6: state_q <= S_CMP;
        S_CMP: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            guess_q     <= guess_d;
            state_q     <= S_IDLE;
          end
        end
        S_UPD: begin
          if (s2_v_q) begin
            if (wr_data[31:30] != 2'b00) begin
              all_small_q <= 1'b0;
            end
            if (wr_data != '0) begin
              all_zero_q <= 1'b0;
            end
          end
          if (!rd_issue && !s1_v_q && !s2_v_q) begin
            rc_q <= '0;
            if (all_zero_q) begin
              state_q <= S_FILL;
            end else if (all_small_q) begin
              state_q <= S_DBL;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_DBL: begin
          if (!rd_issue && !s1_v_q) begin
            state_q <= S_IDLE;
          end
        end
        S_FILL: begin
          if (rc_q < n_eff) begin
            rc_q <= rc_q + CntW'(1);
          end else begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Read pipeline payload, sums and the random draw arithmetic.
  always_ff @(posedge clk_i) begin
    s1_idx_q   <= rc_q[IdxW-1:0];
    s2_idx_q   <= s1_idx_q;
    s2_w_q     <= rd_data;
    s2_wrong_q <= wrong_s1;
    if (state_q == S_IDLE && in_valid_i) begin
      total_q   <= '0;
      sum1_q    <= '0;
      outcome_q <= outcome_i;
    end
    if (state_q == S_SUM && s1_v_q) begin
      total_q <= total_q + SumW'(rd_data);
      if (vote_s1) begin
        sum1_q <= sum1_q + SumW'(rd_data);
      end
    end
    case (state_q)
      S_M1: t_q <= prod[63:32];
      S_M2: t_q <= t_q + prod[31:0];
      S_M3: t_q <= t_q + prod[31:0];
      // floor(t * total / 2^32), built from the low and high total parts.
      S_M5: phi_q <= PhiW'(prod[63:32]);
      S_M6: phi_q <= phi_q + PhiW'(prod[SumW-1:0]);
      default: begin
      end
    endcase
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign cfg_ready_o = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign guess_o     = guess_q;

  // A guess only ever appears at the end of an advice word's comparison.
  `RWM_ASSERT_IMP(a_guess_from_cmp, clk_i, rst_ni, $rose(out_valid_o), $past(state_q) == S_CMP, "guess raised outside the compare step")
  // The read pipeline is drained whenever the sequencer rests.
  `RWM_ASSERT_IMP(a_idle_drained, clk_i, rst_ni, state_q == S_IDLE, !s1_v_q && !s2_v_q, "read pipeline busy while idle")
  // A sweep never runs past the active experts.
  `RWM_ASSERT_IMP(a_sweep_bound, clk_i, rst_ni, state_q != S_IDLE, rc_q <= n_eff, "sweep counter beyond active experts")
  // A taken guess is not shown again unless a new comparison produced it.
  `RWM_ASSERT_NXT(a_no_repeat, clk_i, rst_ni, out_valid_o && !out_stall_i && state_q != S_CMP, !out_valid_o, "guess repeated after it was taken")

endmodule
